/* sv/prac_pkg.sv */
`timescale 1ns / 1ps
package prac_pkg;

  localparam int COORD_W    = 32;
  localparam int ANG_W      = 16;
  localparam int SPLIT_W    = 24;  // low part of a difference word
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd6;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_X0    = 652032874;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] moved_x;
    logic signed [COORD_W-1:0] moved_y;
    logic signed [COORD_W-1:0] moved_z;
    logic                      clipped;
  } moved_t;

  // atan(2^-i), 2^32 counts per turn
  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* sv/prac_cordic.sv */
`timescale 1ns / 1ps
module prac_cordic #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [prac_pkg::ANG_W-1:0]     angle_i,
  output logic                           busy_o,
  output logic signed [COEF_FRAC_BITS+1:0] sin_o,
  output logic signed [COEF_FRAC_BITS+1:0] cos_o
);
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int S  = 30 - COEF_FRAC_BITS;
  localparam logic signed [32:0] QTR  = 33'sd1073741824;
  localparam logic signed [32:0] HTURN = 33'sd2147483648;
  localparam logic signed [33:0] ONE  = 34'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [33:0] MONE = -ONE;
  localparam logic [4:0] LAST_STEP = 5'(prac_pkg::CORDIC_STEPS - 1);

  logic signed [33:0] x_q, x_d, y_q, y_d, xs, ys, xr, yr, xc, yc;
  logic signed [32:0] z_q, z_d, z0, at;
  logic               neg_q, neg_d, busy_q, busy_d;
  logic [4:0]         i_q, i_d;

  always_comb begin
    z0    = 33'($signed({angle_i, 16'h0000}));
    neg_d = neg_q;
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    i_d   = i_q;
    busy_d = busy_q;
    xs    = x_q >>> i_q;
    ys    = y_q >>> i_q;
    at    = $signed({1'b0, prac_pkg::atan_f(i_q)});
    if (start_i) begin
      x_d    = 34'(prac_pkg::CORDIC_X0);
      y_d    = '0;
      i_d    = '0;
      busy_d = 1'b1;
      neg_d  = 1'b0;
      z_d    = z0;
      if (z0 > QTR) begin
        z_d   = z0 - HTURN;
        neg_d = 1'b1;
      end else if (z0 < -QTR) begin
        z_d   = z0 + HTURN;
        neg_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      i_d = i_q + 5'd1;
      if (i_q == LAST_STEP) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  // round half up to the coefficient grid, clamp to +-1.0
  always_comb begin
    xr = (x_q + (34'sd1 <<< (S - 1))) >>> S;
    yr = (y_q + (34'sd1 <<< (S - 1))) >>> S;
    xc = (xr > ONE) ? ONE : ((xr < MONE) ? MONE : xr);
    yc = (yr > ONE) ? ONE : ((yr < MONE) ? MONE : yr);
    if (neg_q) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign busy_o = busy_q;
  assign cos_o  = xc[CW-1:0];
  assign sin_o  = yc[CW-1:0];
endmodule

/* sv/prac_matrix.sv */
`timescale 1ns / 1ps
module prac_matrix #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [3*prac_pkg::ANG_W-1:0]       angles_i,
  output logic                               busy_o,
  output logic signed [COEF_FRAC_BITS+1:0]   coef_o [9]
);
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] ONE  = SW'(1) << COEF_FRAC_BITS;
  localparam logic signed [SW-1:0] MONE = -ONE;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [CW-1:0] C_ONE = CW'(1) << COEF_FRAC_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CORD  = 2'd1;
  localparam logic [1:0] ST_LATCH = 2'd2;
  localparam logic [1:0] ST_MAC   = 2'd3;

  localparam logic [3:0] DST_SASB = 4'd9;
  localparam logic [3:0] DST_CASB = 4'd10;
  localparam logic [3:0] LAST_OP  = 4'd13;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [2:0] cord_busy;
  logic signed [CW-1:0] sn [3];
  logic signed [CW-1:0] cs [3];
  logic signed [CW-1:0] sa_q, ca_q, sb_q, cb_q, sc_q, cc_q, sasb_q, casb_q;
  logic signed [CW-1:0] coef_q [9];

  // operand issue
  logic                 issue;
  logic signed [CW-1:0] op_a, op_b;
  logic                 op_neg, op_first, op_last;
  logic [3:0]           op_dst;

  // multiply stage
  logic                 mv_q, mfirst_q, mlast_q;
  logic [3:0]           mdst_q;
  logic signed [PW-1:0] prod_q;

  // accumulate stage
  logic signed [SW-1:0] acc_q, sum, rsum, csum;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_cordic
      prac_cordic #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cordic (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .start_i (start_i),
        .angle_i (angles_i[g*prac_pkg::ANG_W +: prac_pkg::ANG_W]),
        .busy_o  (cord_busy[g]),
        .sin_o   (sn[g]),
        .cos_o   (cs[g])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CORD;
      ST_CORD: if (cord_busy == 3'b000) state_d = ST_LATCH;
      ST_LATCH: begin
        state_d = ST_MAC;
        step_d  = '0;
      end
      ST_MAC: begin
        if (step_q == LAST_OP + 4'd1) state_d = ST_IDLE;
        else step_d = step_q + 4'd1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign issue = (state_q == ST_MAC) && (step_q <= LAST_OP);

  // product schedule, two-term sums share the accumulator
  always_comb begin
    op_a = sa_q; op_b = sb_q; op_neg = 1'b0; op_first = 1'b1; op_last = 1'b1;
    op_dst = DST_SASB;
    case (step_q)
      4'd0:  begin op_a = sa_q;   op_b = sb_q; op_dst = DST_SASB; end
      4'd1:  begin op_a = ca_q;   op_b = sb_q; op_dst = DST_CASB; end
      4'd2:  begin op_a = cb_q;   op_b = cc_q; op_dst = 4'd0; end
      4'd3:  begin op_a = sasb_q; op_b = cc_q; op_last = 1'b0; end
      4'd4:  begin op_a = ca_q;   op_b = sc_q; op_neg = 1'b1; op_first = 1'b0; op_dst = 4'd1; end
      4'd5:  begin op_a = casb_q; op_b = cc_q; op_last = 1'b0; end
      4'd6:  begin op_a = sa_q;   op_b = sc_q; op_first = 1'b0; op_dst = 4'd2; end
      4'd7:  begin op_a = cb_q;   op_b = sc_q; op_dst = 4'd3; end
      4'd8:  begin op_a = sasb_q; op_b = sc_q; op_last = 1'b0; end
      4'd9:  begin op_a = ca_q;   op_b = cc_q; op_first = 1'b0; op_dst = 4'd4; end
      4'd10: begin op_a = casb_q; op_b = sc_q; op_last = 1'b0; end
      4'd11: begin op_a = sa_q;   op_b = cc_q; op_neg = 1'b1; op_first = 1'b0; op_dst = 4'd5; end
      4'd12: begin op_a = sa_q;   op_b = cb_q; op_dst = 4'd7; end
      4'd13: begin op_a = ca_q;   op_b = cb_q; op_dst = 4'd8; end
      default: ;
    endcase
  end

  always_comb begin
    sum  = (mfirst_q ? '0 : acc_q) + SW'(prod_q);
    rsum = (sum + HALF) >>> COEF_FRAC_BITS;
    csum = (rsum > ONE) ? ONE : ((rsum < MONE) ? MONE : rsum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      mv_q    <= 1'b0;
      for (int k = 0; k < 9; k++) coef_q[k] <= (k % 4 == 0) ? C_ONE : '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mv_q    <= issue;
      if (state_q == ST_LATCH) coef_q[6] <= -sn[1];
      if (mv_q && mlast_q && (mdst_q < 4'd9)) coef_q[mdst_q] <= csum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LATCH) begin
      sa_q <= sn[0]; ca_q <= cs[0];
      sb_q <= sn[1]; cb_q <= cs[1];
      sc_q <= sn[2]; cc_q <= cs[2];
    end
    prod_q   <= op_neg ? -(op_a * op_b) : (op_a * op_b);
    mfirst_q <= op_first;
    mlast_q  <= op_last;
    mdst_q   <= op_dst;
    if (mv_q) begin
      acc_q <= sum;
      if (mlast_q && mdst_q == DST_SASB) sasb_q <= csum[CW-1:0];
      if (mlast_q && mdst_q == DST_CASB) casb_q <= csum[CW-1:0];
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign coef_o = coef_q;
endmodule

/* sv/prac_datapath.sv */
`timescale 1ns / 1ps
module prac_datapath #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  prac_pkg::point_t                    point_i,
  input  logic signed [COEF_FRAC_BITS+1:0]    coef_i [9],
  input  logic signed [prac_pkg::COORD_W-1:0] center_i [3],
  input  logic signed [prac_pkg::COORD_W-1:0] offset_i [3],
  output logic                                valid_o,
  output prac_pkg::moved_t                    result_o
);
  localparam int W    = prac_pkg::COORD_W;
  localparam int LW   = prac_pkg::SPLIT_W;
  localparam int CW   = COEF_FRAC_BITS + 2;
  localparam int DW   = W + 1;
  localparam int DHW  = (DW > LW) ? (DW - LW) : 1;
  localparam int DXW  = DHW + LW;
  localparam int PHW  = CW + DHW;
  localparam int PLW  = CW + LW + 1;
  localparam int SHW  = PHW + 2;
  localparam int SLW  = PLW + 2;
  localparam int VW   = DXW + COEF_FRAC_BITS + 6;
  localparam int TW   = VW + 2;

  logic [4:0] v_q;

  logic signed [W-1:0]   pin [3];
  logic signed [DXW-1:0] dx [3];
  logic signed [DHW-1:0] dh_q [3];
  logic [LW-1:0]         dl_q [3];
  logic signed [PHW-1:0] ph_q [9];
  logic signed [PLW-1:0] pl_q [9];
  logic signed [SHW-1:0] sh_q [3];
  logic signed [SLW-1:0] sl_q [3];
  logic signed [SLW-1:0] slr [3];
  logic signed [VW-1:0]  vv_q [3];
  logic signed [TW-1:0]  t [3];
  logic signed [W-1:0]   sat [3];
  logic [2:0]            clip;
  logic signed [W-1:0]   out_q [3];
  logic                  clip_q;

  assign pin[0] = point_i.point_x;
  assign pin[1] = point_i.point_y;
  assign pin[2] = point_i.point_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k]  = DXW'(DW'(pin[k]) - DW'(center_i[k]));
      slr[k] = (sl_q[k] + (SLW'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      t[k]   = TW'(vv_q[k]) + TW'(center_i[k]) - TW'(offset_i[k]);
      clip[k] = (t[k][TW-1:W-1] != {(TW-W+1){t[k][TW-1]}});
      if (clip[k]) sat[k] = t[k][TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      else sat[k] = t[k][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[3:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      // difference split so each product stays narrow
      dh_q[k] <= dx[k][DXW-1:LW];
      dl_q[k] <= dx[k][LW-1:0];
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ph_q[r*3+k] <= coef_i[r*3+k] * dh_q[k];
        pl_q[r*3+k] <= coef_i[r*3+k] * $signed({1'b0, dl_q[k]});
      end
    end
    for (int r = 0; r < 3; r++) begin
      sh_q[r] <= SHW'(ph_q[r*3]) + SHW'(ph_q[r*3+1]) + SHW'(ph_q[r*3+2]);
      sl_q[r] <= SLW'(pl_q[r*3]) + SLW'(pl_q[r*3+1]) + SLW'(pl_q[r*3+2]);
      vv_q[r] <= (VW'(sh_q[r]) <<< (LW - COEF_FRAC_BITS)) + VW'(slr[r]);
      out_q[r] <= sat[r];
    end
    clip_q <= |clip;
  end

  assign valid_o           = v_q[4];
  assign result_o.moved_x  = out_q[0];
  assign result_o.moved_y  = out_q[1];
  assign result_o.moved_z  = out_q[2];
  assign result_o.clipped  = clip_q;
endmodule

/* sv/point_rotate_about_center.sv */
`timescale 1ns / 1ps
// Rigid transform of 3D points: R * (p - center) + center - offset,
// with R = Rz * Ry * Rx built from three binary angles.
//
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i write one register per
// clock, no wait. Index 0 holds the packed angles (x in 15:0, y in 31:16,
// z in 47:32); 1..3 the center, 4..6 the offset. Other indexes are ignored.
// An angle write starts the coefficient engine: three CORDIC units run 30
// steps in parallel, then one shared multiplier walks 14 products; busy_o
// is high meanwhile, the write cycle included.
//
// Points: a word is taken at each edge with start_i high and busy_o low,
// one per cycle. Five register stages (difference, products, row sums,
// rounding, offset and clamp), the first loaded at the accepting edge; the
// result word shows on result_o with result_valid_o high for one cycle
// once the offset and clamp stage holds it.
// The receiver cannot stall the flow.
//
// Reset: coefficients hold the identity, center and offset are zero.
module point_rotate_about_center #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  prac_pkg::point_t                     point_i,
  output logic                                 busy_o,
  input  logic                                 cfg_we_i,
  input  logic [prac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [prac_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 result_valid_o,
  output prac_pkg::moved_t                     result_o
);
  localparam int W = prac_pkg::COORD_W;

  logic                          angle_wr;
  logic                          mat_busy;
  logic signed [COEF_FRAC_BITS+1:0] coef [9];
  logic signed [W-1:0]           center_q [3];
  logic signed [W-1:0]           offset_q [3];
  logic                          accept;

  assign angle_wr = cfg_we_i && (cfg_idx_i == prac_pkg::CFG_ANGLES);

  // Center and offset registers; the angle word goes straight to the engine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        center_q[k] <= '0;
        offset_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prac_pkg::CFG_CENTER_X: center_q[0] <= cfg_data_i[W-1:0];
        prac_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data_i[W-1:0];
        prac_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data_i[W-1:0];
        prac_pkg::CFG_OFFSET_X: offset_q[0] <= cfg_data_i[W-1:0];
        prac_pkg::CFG_OFFSET_Y: offset_q[1] <= cfg_data_i[W-1:0];
        prac_pkg::CFG_OFFSET_Z: offset_q[2] <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  prac_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (angle_wr),
    .angles_i (cfg_data_i),
    .busy_o   (mat_busy),
    .coef_o   (coef)
  );

  // busy also covers the cycle of an angle write, before the engine starts
  assign busy_o = mat_busy || angle_wr;
  assign accept = start_i && !busy_o;

  prac_datapath #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .point_i  (point_i),
    .coef_i   (coef),
    .center_i (center_q),
    .offset_i (offset_q),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );
endmodule
